// ----- hw/rtl/vhc_pkg.sv -----
// ----------------------------------------------------------------------------
// vhc_pkg
// Types, codes and range helpers shared by the version handshake checker.
// ----------------------------------------------------------------------------
package vhc_pkg;

	// Handshake phases, as reported in handshake_state
	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_PROTO = 4'd1,
		PH_APP   = 4'd2,
		PH_COMB  = 4'd3,
		PH_LEN   = 4'd4,
		PH_NAME  = 4'd5,
		PH_EXTRA = 4'd6,
		PH_DONE  = 4'd7,
		PH_CONN  = 4'd8,
		PH_ERR   = 4'd9
	} phase_t;

	// Item kinds on the input stream (tuser)
	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_OWN_VERSION    = 3'd0,
		CFG_LOCAL_PROTOCOL = 3'd1,
		CFG_NAME_LENGTH    = 3'd2,
		CFG_NAME_LOW       = 3'd3,
		CFG_NAME_HIGH      = 3'd4
	} cfg_idx_t;

	localparam logic [7:0] VERSION_MSG_ID    = 8'd0;
	localparam logic [7:0] MIN_START_SIZE    = 8'd3;
	localparam logic [7:0] NAME_OFFSET       = 8'd4;
	localparam logic [7:0] PEER_VERSION_RST  = 8'hF0;
	localparam logic [7:0] OWN_VERSION_RST   = 8'h00;
	localparam logic [7:0] LOCAL_PROTO_RST   = 8'h11;

	// Input payload, first field in the low bits
	typedef struct packed {
		logic [5:0] pad;
		logic       is_request;
		logic       message_ok;
		logic [7:0] byte_offset;
		logic [7:0] data_byte;
		logic [7:0] total_size;
		logic [7:0] message_id;
	} in_item_t;

	// Result payload, first field in the low bits
	typedef struct packed {
		logic       pad;
		logic       send_reply;
		logic [7:0] combined_version;
		logic [7:0] protocol_version;
		logic [3:0] handshake_state;
		logic       connected;
		logic       accepted;
	} res_item_t;

	// Merge two ranges: smaller maximum (high nibble), larger minimum (low nibble)
	function automatic logic [7:0] merge_range(input logic [7:0] a, input logic [7:0] b);
		logic [3:0] hi;
		logic [3:0] lo;
		hi = (a[7:4] > b[7:4]) ? b[7:4] : a[7:4];
		lo = (a[3:0] < b[3:0]) ? b[3:0] : a[3:0];
		return {hi, lo};
	endfunction

	// A range is usable when its maximum is not below its minimum
	function automatic logic range_ok(input logic [7:0] v);
		return v[7:4] >= v[3:0];
	endfunction

endpackage

// ----- hw/rtl/version_handshake_checker.sv -----
// ----------------------------------------------------------------------------
// version_handshake_checker
// Walks a version-handshake message byte by byte, negotiates protocol and
// app version ranges, checks the app name and reports the handshake state.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_axis    in   tvalid/tready       tuser: command; tdata: message fields
//  m_axis    out  tvalid/tready       tdata: one result per input item
//  cfg       in   cfg_we (no wait)    cfg_index, cfg_data
//
//  One item per clock sustained while m_axis takes results. A result is
//  offered from the output buffer: the item sits in the input register, then
//  it is folded into the handshake state and written to a two-entry output
//  buffer. s_axis_tready comes from registers only; it drops when the input
//  register holds an item and the output buffer is full.
//  Reset sets state (not the length byte) and configuration to defaults and empties the buffer.
module version_handshake_checker (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // message_id, total_size, data_byte,
	                                   // byte_offset, message_ok, is_request, zeros
	input  logic [1:0]  s_axis_tuser,  // command
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // accepted, connected, handshake_state,
	                                   // protocol_version, combined_version,
	                                   // send_reply, zero
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	// configuration registers
	logic [7:0]   own_version_q;
	logic [7:0]   local_proto_q;
	logic [3:0]   name_length_q;
	logic [63:0]  name_low_q;
	logic [55:0]  name_high_q;

	// handshake state
	vhc_pkg::phase_t phase_q, phase_d;
	logic         linked_q, linked_d;
	logic [7:0]   neg_proto_q, neg_proto_d;
	logic [7:0]   peer_ver_q, peer_ver_d;
	logic [7:0]   agreed_q, agreed_d;
	logic [7:0]   len_byte_q, len_byte_d;

	// input register
	logic              valid_s1;
	vhc_pkg::in_item_t item_s1;
	vhc_pkg::cmd_t     cmd_s1;
	logic              adv_s1;

	// output buffer
	vhc_pkg::res_item_t buf_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;
	logic              buf_full;
	logic              pop;
	vhc_pkg::res_item_t res;

	// name compare helpers
	logic [127:0] name_all;
	logic [7:0]   name_idx;
	logic [7:0]   name_sel;
	logic [7:0]   extra_idx;

	assign buf_full      = (count_q == 2'd2);
	assign adv_s1        = valid_s1 && !buf_full;
	assign s_axis_tready = !valid_s1 || !buf_full;
	assign pop           = m_axis_tvalid && m_axis_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_version_q <= vhc_pkg::OWN_VERSION_RST;
			local_proto_q <= vhc_pkg::LOCAL_PROTO_RST;
			name_length_q <= '0;
			name_low_q    <= '0;
			name_high_q   <= '0;
		end else if (cfg_we) begin
			unique case (vhc_pkg::cfg_idx_t'(cfg_index))
				vhc_pkg::CFG_OWN_VERSION:    own_version_q <= cfg_data[7:0];
				vhc_pkg::CFG_LOCAL_PROTOCOL: local_proto_q <= cfg_data[7:0];
				vhc_pkg::CFG_NAME_LENGTH:    name_length_q <= cfg_data[3:0];
				vhc_pkg::CFG_NAME_LOW:       name_low_q    <= cfg_data;
				vhc_pkg::CFG_NAME_HIGH:      name_high_q   <= cfg_data[55:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= vhc_pkg::in_item_t'(s_axis_tdata);
			cmd_s1  <= vhc_pkg::cmd_t'(s_axis_tuser);
		end
	end

	// name byte lookup, padded so every 4-bit index is in range
	assign name_all  = {8'h00, name_high_q, name_low_q};
	assign name_idx  = item_s1.byte_offset - vhc_pkg::NAME_OFFSET;
	assign name_sel  = name_all[{name_idx[3:0], 3'b000} +: 8];
	assign extra_idx = item_s1.byte_offset - vhc_pkg::NAME_OFFSET - {4'd0, len_byte_q[3:0]};

	// next handshake state and result
	always_comb begin
		phase_d     = phase_q;
		linked_d    = linked_q;
		neg_proto_d = neg_proto_q;
		peer_ver_d  = peer_ver_q;
		agreed_d    = agreed_q;
		len_byte_d  = len_byte_q;
		res         = '0;

		if (item_s1.message_id == vhc_pkg::VERSION_MSG_ID) begin
			case (cmd_s1)
				vhc_pkg::CMD_START: begin
					if (item_s1.total_size >= vhc_pkg::MIN_START_SIZE) begin
						phase_d      = vhc_pkg::PH_PROTO;
						res.accepted = 1'b1;
					end
				end
				vhc_pkg::CMD_DATA: begin
					unique case (phase_q)
						vhc_pkg::PH_PROTO: begin
							neg_proto_d = vhc_pkg::merge_range(local_proto_q,
								item_s1.data_byte);
							phase_d = vhc_pkg::range_ok(neg_proto_d) ?
								vhc_pkg::PH_APP : vhc_pkg::PH_ERR;
						end
						vhc_pkg::PH_APP: begin
							peer_ver_d = item_s1.data_byte;
							phase_d    = vhc_pkg::PH_COMB;
						end
						vhc_pkg::PH_COMB: begin
							peer_ver_d = vhc_pkg::merge_range(peer_ver_q, item_s1.data_byte);
							agreed_d   = vhc_pkg::merge_range(own_version_q, peer_ver_d);
							phase_d    = vhc_pkg::range_ok(agreed_d) ?
								vhc_pkg::PH_LEN : vhc_pkg::PH_ERR;
						end
						vhc_pkg::PH_LEN: begin
							len_byte_d = item_s1.data_byte;
							phase_d    = (name_length_q == item_s1.data_byte[3:0]) ?
								vhc_pkg::PH_NAME : vhc_pkg::PH_ERR;
						end
						vhc_pkg::PH_NAME: begin
							// index past the name, or a differing byte, fails
							if (name_idx >= {4'd0, name_length_q} ||
									item_s1.data_byte != name_sel) begin
								phase_d = vhc_pkg::PH_ERR;
							end else if ({1'b0, name_idx} + 9'd1 >= {5'd0, name_length_q}) begin
								phase_d = (len_byte_q[7:4] == 4'd0) ?
									vhc_pkg::PH_DONE : vhc_pkg::PH_EXTRA;
							end
						end
						vhc_pkg::PH_EXTRA: begin
							if ({1'b0, extra_idx} + 9'd1 >= {5'd0, len_byte_q[7:4]}) begin
								phase_d = vhc_pkg::PH_DONE;
							end
						end
						default: phase_d = vhc_pkg::PH_ERR;
					endcase
				end
				vhc_pkg::CMD_FINISH: begin
					if (phase_q == vhc_pkg::PH_DONE && item_s1.message_ok) begin
						linked_d       = 1'b1;
						phase_d        = vhc_pkg::PH_CONN;
						res.send_reply = item_s1.is_request;
					end else begin
						linked_d    = 1'b0;
						neg_proto_d = local_proto_q;
					end
				end
				default: ;
			endcase
		end

		res.connected        = linked_d;
		res.handshake_state  = phase_d;
		res.protocol_version = neg_proto_d;
		res.combined_version = agreed_d;
	end

	// state update, one item per cycle while the output buffer has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= vhc_pkg::PH_IDLE;
			linked_q    <= 1'b0;
			neg_proto_q <= vhc_pkg::LOCAL_PROTO_RST;
			peer_ver_q  <= vhc_pkg::PEER_VERSION_RST;
			agreed_q    <= vhc_pkg::OWN_VERSION_RST;
		end else if (adv_s1) begin
			phase_q     <= phase_d;
			linked_q    <= linked_d;
			neg_proto_q <= neg_proto_d;
			peer_ver_q  <= peer_ver_d;
			agreed_q    <= agreed_d;
		end
	end

	// length byte is always written before it is read
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			len_byte_q <= len_byte_d;
		end
	end

	// output buffer data
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	// output buffer pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (adv_s1) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({adv_s1, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = (count_q != 2'd0);
	assign m_axis_tdata  = buf_q[rd_ptr_q];

endmodule

// ----- hw/rtl/vhc_checker.sv -----
// ----------------------------------------------------------------------------
// vhc_checker
// Port-level checks for the version handshake checker, bound to the top.
// ----------------------------------------------------------------------------
module vhc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	vhc_pkg::res_item_t res;
	assign res = vhc_pkg::res_item_t'(m_axis_tdata);

	// a stalled result transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input back-pressure only while results are pending
	a_bp_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

	// a reply request only comes with a completed connection
	a_reply_conn: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.send_reply |->
			res.connected && res.handshake_state == vhc_pkg::PH_CONN)
		else $error("reply without connection");

	// an accepted start always arms the protocol version phase
	a_accept_arm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.accepted |-> res.handshake_state == vhc_pkg::PH_PROTO)
		else $error("accepted start did not arm");

endmodule

bind version_handshake_checker vhc_checker u_vhc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
